>>> src/qivr_pkg.sv
// Shared types, index names and width helpers for the quaternion inverse rotator.
// Used by the pipeline stages and the top level; depends on nothing else.
`default_nettype none

package qivr_pkg;

	localparam int unsigned NSTG = 5;

	localparam int unsigned STG_PROD = 0;
	localparam int unsigned STG_MAT  = 1;
	localparam int unsigned STG_PART = 2;
	localparam int unsigned STG_SUM  = 3;
	localparam int unsigned STG_OUT  = 4;

	localparam int unsigned QX = 0;
	localparam int unsigned QY = 1;
	localparam int unsigned QZ = 2;
	localparam int unsigned QW = 3;

	localparam int unsigned VX = 0;
	localparam int unsigned VY = 1;
	localparam int unsigned VZ = 2;

	localparam int unsigned PXX = 0;
	localparam int unsigned PYY = 1;
	localparam int unsigned PZZ = 2;
	localparam int unsigned PXY = 3;
	localparam int unsigned PXZ = 4;
	localparam int unsigned PYZ = 5;
	localparam int unsigned PWX = 6;
	localparam int unsigned PWY = 7;
	localparam int unsigned PWZ = 8;

	localparam int unsigned M00 = 0;
	localparam int unsigned M01 = 1;
	localparam int unsigned M02 = 2;
	localparam int unsigned M10 = 3;
	localparam int unsigned M11 = 4;
	localparam int unsigned M12 = 5;
	localparam int unsigned M20 = 6;
	localparam int unsigned M21 = 7;
	localparam int unsigned M22 = 8;

	typedef struct packed {
		logic [NSTG-1:0] load;
		logic [NSTG-1:0] valid;
	} ctl_t;

	// Signed width that holds every rotation matrix entry exactly.
	function automatic int unsigned mat_w(input int unsigned dw, input int unsigned qf);
		return ((dw > qf) ? 2 * dw : 2 * qf) + 2;
	endfunction

endpackage

`default_nettype wire

>>> src/qivr_item_if.sv
// Request channel carrying one quaternion and one vector per transfer.
// Stand-alone valid/ready interface; no dependencies.
`default_nettype none

interface qivr_item_if #(
	parameter int unsigned DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] quat_x;
	logic signed [DATA_WIDTH-1:0] quat_y;
	logic signed [DATA_WIDTH-1:0] quat_z;
	logic signed [DATA_WIDTH-1:0] quat_w;
	logic signed [DATA_WIDTH-1:0] vec_x;
	logic signed [DATA_WIDTH-1:0] vec_y;
	logic signed [DATA_WIDTH-1:0] vec_z;

	modport source (
		output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
		input  ready
	);
	modport sink (
		input  valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
		output ready
	);
endinterface

`default_nettype wire

>>> src/qivr_result_if.sv
// Result channel carrying one rotated vector and its saturation flag.
// Stand-alone valid/ready interface; no dependencies.
`default_nettype none

interface qivr_result_if #(
	parameter int unsigned DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] rot_x;
	logic signed [DATA_WIDTH-1:0] rot_y;
	logic signed [DATA_WIDTH-1:0] rot_z;
	logic                         clipped;

	modport source (
		output valid, rot_x, rot_y, rot_z, clipped,
		input  ready
	);
	modport sink (
		input  valid, rot_x, rot_y, rot_z, clipped,
		output ready
	);
endinterface

`default_nettype wire

>>> src/quaternion_inverse_vector_rotate_top.sv
// Rotates a vector by the inverse of a Q2.14 quaternion, five pipeline stages.
// Each request passes through five register stages: products, matrix, partial products, row sums, output.
// Throughput: one request per cycle unless the result side stalls; each stage holds its item while stalled.
// Reset (arst_n, asynchronous, active low) clears the stage valid bits only.
// Depends on qivr_pkg, the two channel interfaces and the qivr_* stages.
`default_nettype none

module quaternion_inverse_vector_rotate_top #(
	parameter int unsigned DATA_WIDTH     = 16,
	parameter int unsigned QUAT_FRAC_BITS = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	qivr_item_if.sink     item,
	qivr_result_if.source result
);
	import qivr_pkg::*;

	localparam int unsigned PW  = 2 * DATA_WIDTH;
	localparam int unsigned MW  = mat_w(DATA_WIDTH, QUAT_FRAC_BITS);
	localparam int unsigned HSW = MW + 2;
	localparam int unsigned LSW = 2 * DATA_WIDTH + 3;

	localparam logic signed [DATA_WIDTH-1:0] SAT_POS = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SAT_NEG = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

	ctl_t                         ctl;
	logic signed [PW-1:0]         prod_s1 [9];
	logic signed [DATA_WIDTH-1:0] vec_s1 [3];
	logic signed [MW-1:0]         mat_s2 [9];
	logic signed [DATA_WIDTH-1:0] vec_s2 [3];
	logic signed [HSW-1:0]        hsum_s4 [3];
	logic signed [LSW-1:0]        lsum_s4 [3];
	logic signed [DATA_WIDTH-1:0] rot_s5 [3];
	logic                         clip_s5;

	qivr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.out_ready (result.ready),
		.in_ready  (item.ready),
		.ctl       (ctl)
	);

	qivr_qprod #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_qprod (
		.clk     (clk),
		.ctl     (ctl),
		.quat_x  (item.quat_x),
		.quat_y  (item.quat_y),
		.quat_z  (item.quat_z),
		.quat_w  (item.quat_w),
		.vec_x   (item.vec_x),
		.vec_y   (item.vec_y),
		.vec_z   (item.vec_z),
		.prod_s1 (prod_s1),
		.vec_s1  (vec_s1)
	);

	qivr_matrix #(
		.DATA_WIDTH     (DATA_WIDTH),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_matrix (
		.clk     (clk),
		.ctl     (ctl),
		.prod_s1 (prod_s1),
		.vec_s1  (vec_s1),
		.mat_s2  (mat_s2),
		.vec_s2  (vec_s2)
	);

	qivr_mac #(
		.DATA_WIDTH     (DATA_WIDTH),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_mac (
		.clk     (clk),
		.ctl     (ctl),
		.mat_s2  (mat_s2),
		.vec_s2  (vec_s2),
		.hsum_s4 (hsum_s4),
		.lsum_s4 (lsum_s4)
	);

	qivr_round #(
		.DATA_WIDTH     (DATA_WIDTH),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_round (
		.clk     (clk),
		.ctl     (ctl),
		.hsum_s4 (hsum_s4),
		.lsum_s4 (lsum_s4),
		.rot_s5  (rot_s5),
		.clip_s5 (clip_s5)
	);

	assign result.valid   = ctl.valid[STG_OUT];
	assign result.rot_x   = rot_s5[VX];
	assign result.rot_y   = rot_s5[VY];
	assign result.rot_z   = rot_s5[VZ];
	assign result.clipped = clip_s5;

`ifndef SYNTH
	// A clipped result has at least one component pinned at a bound.
	a_clip_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.clipped |->
			result.rot_x == SAT_POS || result.rot_x == SAT_NEG ||
			result.rot_y == SAT_POS || result.rot_y == SAT_NEG ||
			result.rot_z == SAT_POS || result.rot_z == SAT_NEG)
		else $error("clipped result without a saturated component");

	// With the result side ready, no stage can hold back the request side.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> item.ready)
		else $error("request stalled while the result side is ready");

	// Back-pressure on requests only comes from an occupied first stage.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> ctl.valid[STG_PROD])
		else $error("request stalled with an empty first stage");

	// An accepted request occupies the first stage on the next cycle.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> ctl.valid[STG_PROD])
		else $error("accepted request not captured");
`endif

endmodule

`default_nettype wire

>>> src/qivr_ctrl.sv
// Valid bits and per-stage load enables of the five-stage rotator pipeline.
// Depends on qivr_pkg.
`default_nettype none

module qivr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	output logic            in_ready,
	output qivr_pkg::ctl_t  ctl
);
	import qivr_pkg::*;

	logic [NSTG-1:0] valid_q;
	logic [NSTG-1:0] ready;

	// A stage can load when it is empty or its contents move on this cycle.
	assign ready[NSTG-1] = !valid_q[NSTG-1] || out_ready;
	for (genvar k = 0; k < NSTG - 1; k++) begin : g_ready
		assign ready[k] = !valid_q[k] || ready[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (valid_q & ~ready) | (ready & {valid_q[NSTG-2:0], in_valid});
		end
	end

	assign in_ready  = ready[0];
	assign ctl.load  = ready;
	assign ctl.valid = valid_q;

endmodule

`default_nettype wire

>>> src/qivr_qprod.sv
// Stage one: the nine pairwise quaternion products, with the vector carried along.
// Depends on qivr_pkg.
`default_nettype none

module qivr_qprod #(
	parameter int unsigned DATA_WIDTH     = 16,
	localparam int unsigned PW            = 2 * DATA_WIDTH
) (
	input  logic                         clk,
	input  qivr_pkg::ctl_t               ctl,
	input  logic signed [DATA_WIDTH-1:0] quat_x,
	input  logic signed [DATA_WIDTH-1:0] quat_y,
	input  logic signed [DATA_WIDTH-1:0] quat_z,
	input  logic signed [DATA_WIDTH-1:0] quat_w,
	input  logic signed [DATA_WIDTH-1:0] vec_x,
	input  logic signed [DATA_WIDTH-1:0] vec_y,
	input  logic signed [DATA_WIDTH-1:0] vec_z,
	output logic signed [PW-1:0]         prod_s1 [9],
	output logic signed [DATA_WIDTH-1:0] vec_s1 [3]
);
	import qivr_pkg::*;

	logic signed [PW-1:0] qe [4];

	assign qe[QX] = PW'(quat_x);
	assign qe[QY] = PW'(quat_y);
	assign qe[QZ] = PW'(quat_z);
	assign qe[QW] = PW'(quat_w);

	always_ff @(posedge clk) begin
		if (ctl.load[STG_PROD]) begin
			prod_s1[PXX] <= qe[QX] * qe[QX];
			prod_s1[PYY] <= qe[QY] * qe[QY];
			prod_s1[PZZ] <= qe[QZ] * qe[QZ];
			prod_s1[PXY] <= qe[QX] * qe[QY];
			prod_s1[PXZ] <= qe[QX] * qe[QZ];
			prod_s1[PYZ] <= qe[QY] * qe[QZ];
			prod_s1[PWX] <= qe[QW] * qe[QX];
			prod_s1[PWY] <= qe[QW] * qe[QY];
			prod_s1[PWZ] <= qe[QW] * qe[QZ];
			vec_s1[VX]   <= vec_x;
			vec_s1[VY]   <= vec_y;
			vec_s1[VZ]   <= vec_z;
		end
	end

endmodule

`default_nettype wire

>>> src/qivr_matrix.sv
// Stage two: forms the nine entries of the transposed rotation matrix.
// Depends on qivr_pkg.
`default_nettype none

module qivr_matrix #(
	parameter int unsigned DATA_WIDTH     = 16,
	parameter int unsigned QUAT_FRAC_BITS = 14,
	localparam int unsigned PW            = 2 * DATA_WIDTH,
	localparam int unsigned MW            = qivr_pkg::mat_w(DATA_WIDTH, QUAT_FRAC_BITS)
) (
	input  logic                         clk,
	input  qivr_pkg::ctl_t               ctl,
	input  logic signed [PW-1:0]         prod_s1 [9],
	input  logic signed [DATA_WIDTH-1:0] vec_s1 [3],
	output logic signed [MW-1:0]         mat_s2 [9],
	output logic signed [DATA_WIDTH-1:0] vec_s2 [3]
);
	import qivr_pkg::*;

	localparam logic signed [MW-1:0] ONE = MW'(1) << (2 * QUAT_FRAC_BITS);

	logic signed [MW-1:0] pe [9];

	for (genvar k = 0; k < 9; k++) begin : g_ext
		assign pe[k] = MW'(prod_s1[k]);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[STG_MAT]) begin
			mat_s2[M00] <= ONE - ((pe[PYY] + pe[PZZ]) <<< 1);
			mat_s2[M01] <= (pe[PXY] + pe[PWZ]) <<< 1;
			mat_s2[M02] <= (pe[PXZ] - pe[PWY]) <<< 1;
			mat_s2[M10] <= (pe[PXY] - pe[PWZ]) <<< 1;
			mat_s2[M11] <= ONE - ((pe[PXX] + pe[PZZ]) <<< 1);
			mat_s2[M12] <= (pe[PYZ] + pe[PWX]) <<< 1;
			mat_s2[M20] <= (pe[PXZ] + pe[PWY]) <<< 1;
			mat_s2[M21] <= (pe[PYZ] - pe[PWX]) <<< 1;
			mat_s2[M22] <= ONE - ((pe[PXX] + pe[PYY]) <<< 1);
			vec_s2      <= vec_s1;
		end
	end

endmodule

`default_nettype wire

>>> src/qivr_mac.sv
// Stages three and four: split-operand products of matrix entries and vector,
// then the high and low partial sums of each row. Depends on qivr_pkg.
`default_nettype none

module qivr_mac #(
	parameter int unsigned DATA_WIDTH     = 16,
	parameter int unsigned QUAT_FRAC_BITS = 14,
	localparam int unsigned MW            = qivr_pkg::mat_w(DATA_WIDTH, QUAT_FRAC_BITS),
	localparam int unsigned HW            = MW - DATA_WIDTH,
	localparam int unsigned HPW           = HW + DATA_WIDTH,
	localparam int unsigned LPW           = 2 * DATA_WIDTH + 1,
	localparam int unsigned HSW           = HPW + 2,
	localparam int unsigned LSW           = LPW + 2
) (
	input  logic                         clk,
	input  qivr_pkg::ctl_t               ctl,
	input  logic signed [MW-1:0]         mat_s2 [9],
	input  logic signed [DATA_WIDTH-1:0] vec_s2 [3],
	output logic signed [HSW-1:0]        hsum_s4 [3],
	output logic signed [LSW-1:0]        lsum_s4 [3]
);
	import qivr_pkg::*;

	logic signed [HPW-1:0] ph_s3 [9];
	logic signed [LPW-1:0] pl_s3 [9];

	// Each entry is split into a signed high part and an unsigned low part.
	for (genvar e = 0; e < 9; e++) begin : g_part
		logic signed [HW-1:0]         hi;
		logic signed [DATA_WIDTH:0]   lo;
		assign hi = $signed(mat_s2[e][MW-1:DATA_WIDTH]);
		assign lo = $signed({1'b0, mat_s2[e][DATA_WIDTH-1:0]});

		always_ff @(posedge clk) begin
			if (ctl.load[STG_PART]) begin
				ph_s3[e] <= HPW'(hi) * HPW'(vec_s2[e % 3]);
				pl_s3[e] <= LPW'(lo) * LPW'(vec_s2[e % 3]);
			end
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		always_ff @(posedge clk) begin
			if (ctl.load[STG_SUM]) begin
				hsum_s4[r] <= HSW'(ph_s3[3*r]) + HSW'(ph_s3[3*r+1]) + HSW'(ph_s3[3*r+2]);
				lsum_s4[r] <= LSW'(pl_s3[3*r]) + LSW'(pl_s3[3*r+1]) + LSW'(pl_s3[3*r+2]);
			end
		end
	end

endmodule

`default_nettype wire

>>> src/qivr_round.sv
// Stage five: joins the partial sums, rounds half up to the vector scale and
// saturates each component. Depends on qivr_pkg.
`default_nettype none

module qivr_round #(
	parameter int unsigned DATA_WIDTH     = 16,
	parameter int unsigned QUAT_FRAC_BITS = 14,
	localparam int unsigned MW            = qivr_pkg::mat_w(DATA_WIDTH, QUAT_FRAC_BITS),
	localparam int unsigned HSW           = MW + 2,
	localparam int unsigned LSW           = 2 * DATA_WIDTH + 3
) (
	input  logic                         clk,
	input  qivr_pkg::ctl_t               ctl,
	input  logic signed [HSW-1:0]        hsum_s4 [3],
	input  logic signed [LSW-1:0]        lsum_s4 [3],
	output logic signed [DATA_WIDTH-1:0] rot_s5 [3],
	output logic                         clip_s5
);
	import qivr_pkg::*;

	localparam int unsigned TW = HSW + DATA_WIDTH + 1;
	localparam int unsigned SH = 2 * QUAT_FRAC_BITS;
	localparam int unsigned QV = TW - SH;

	localparam logic signed [TW-1:0] HALF   = TW'(1) << (SH - 1);
	localparam logic signed [QV-1:0] SAT_HI =
		{{(QV - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic signed [QV-1:0] SAT_LO =
		{{(QV - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};

	logic signed [DATA_WIDTH-1:0] sat [3];
	logic [2:0]                   over;

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [TW-1:0] total;
		logic signed [QV-1:0] qv;
		assign total = (TW'(hsum_s4[r]) <<< DATA_WIDTH) + TW'(lsum_s4[r]) + HALF;
		assign qv    = $signed(total[TW-1:SH]);

		always_comb begin
			over[r] = 1'b1;
			if (qv > SAT_HI) begin
				sat[r] = SAT_HI[DATA_WIDTH-1:0];
			end else if (qv < SAT_LO) begin
				sat[r] = SAT_LO[DATA_WIDTH-1:0];
			end else begin
				sat[r]  = qv[DATA_WIDTH-1:0];
				over[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[STG_OUT]) begin
			rot_s5  <= sat;
			clip_s5 <= |over;
		end
	end

endmodule

`default_nettype wire
